/* design/saw_pkg.sv */
// shared types and constants for the self-avoiding walk site stack
`default_nettype none
package saw_pkg;

  // field widths
  localparam int COORD_W = 12;
  localparam int LEN_W   = 11;
  localparam int DIM_W   = 2;
  localparam int OP_W    = 2;
  localparam int DIR_W   = 3;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;

  // fan-in of one level of the hit reduction tree
  localparam int FAN = 32;

  // opcodes
  localparam logic [OP_W-1:0] OP_EXTEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_RETRACT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // step directions
  localparam logic [DIR_W-1:0] DIR_PY = 3'd0;
  localparam logic [DIR_W-1:0] DIR_PX = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NY = 3'd2;
  localparam logic [DIR_W-1:0] DIR_NX = 3'd3;
  localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
  localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;
  localparam logic [DIR_W-1:0] DIR_LIMIT_2D = 3'd4;
  localparam logic [DIR_W-1:0] DIR_LIMIT_3D = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] ST_EXTENDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_RETRACTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH = 1'd1;

  localparam logic [DIM_W-1:0] DIM_3D = 2'd3;
  localparam logic [DIM_W-1:0] DIM_RESET = 2'd2;
  localparam logic [LEN_W-1:0] TARGET_RESET = 11'd1024;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } site_t;

  // shift control for the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP,
    ACT_CLEAR
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TREE1,
    S_TREE2,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

/* design/saw_in_if.sv */
// input channel: opcode and step direction words
`default_nettype none
interface saw_in_if import saw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [DIR_W-1:0] step_direction;

  modport source (output valid, output opcode, output step_direction, input ready);
  modport sink   (input valid, input opcode, input step_direction, output ready);
endinterface
`default_nettype wire

/* design/saw_out_if.sv */
// output channel: status, walk length and end site words
`default_nettype none
interface saw_out_if import saw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic [LEN_W-1:0]          walk_length;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic signed [COORD_W-1:0] end_z;

  modport source (output valid, output status, output walk_length,
                  output end_x, output end_y, output end_z, input ready);
  modport sink   (input valid, input status, input walk_length,
                  input end_x, input end_y, input end_z, output ready);
endinterface
`default_nettype wire

/* design/saw_cell.sv */
// one stack cell: holds a site, shifts with its neighbors, compares against the candidate
`default_nettype none
module saw_cell import saw_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 11
) (
  input  wire logic             clk,
  input  wire stack_ctl_t       ctl,
  input  wire site_t            above,
  input  wire site_t            below,
  input  wire logic [CNT_W-1:0] count,
  input  wire site_t            cand,
  output site_t                 site,
  output logic                  hit
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic active;

  // cell holds a live site when its depth is below the walk length
  assign active = MY_IDX < count;

  // push moves sites deeper, pop moves them back up
  always_ff @(posedge clk) begin
    priority if (ctl.push) begin
      site <= above;
    end else if (ctl.pop) begin
      site <= below;
    end
  end

  // registered match against the broadcast candidate
  always_ff @(posedge clk) begin
    hit <= active && (site == cand);
  end

endmodule
`default_nettype wire

/* design/saw_hit_tree.sv */
// two registered OR levels that fold the per-cell hits into one flag
`default_nettype none
module saw_hit_tree import saw_pkg::*; #(
  parameter int N = 1024
) (
  input  wire logic         clk,
  input  wire logic [N-1:0] hits,
  output logic              any_hit
);

  localparam int G1_N   = (N + FAN - 1) / FAN;
  localparam int G2_N   = (G1_N + FAN - 1) / FAN;
  localparam int PAD1_W = G1_N * FAN;
  localparam int PAD2_W = G2_N * FAN;

  logic [PAD1_W-1:0] hits_pad;
  logic [G1_N-1:0]   g1;
  logic [PAD2_W-1:0] g1_pad;
  logic [G2_N-1:0]   g2;

  assign hits_pad = PAD1_W'(hits);
  assign g1_pad   = PAD2_W'(g1);

  // first level: one register per group of cells
  always_ff @(posedge clk) begin
    for (int g = 0; g < G1_N; g++) begin
      g1[g] <= |hits_pad[g*FAN +: FAN];
    end
  end

  // second level
  always_ff @(posedge clk) begin
    for (int g = 0; g < G2_N; g++) begin
      g2[g] <= |g1_pad[g*FAN +: FAN];
    end
  end

  assign any_hit = |g2;

endmodule
`default_nettype wire

/* design/self_avoiding_walk_site_stack.sv */
// top level: walk control, cell chain and result register
//
// Keeps a lattice walk from the origin as a stack of MAX_LEN cells, newest site
// in cell 0; a push or pop shifts every cell one place at once. One item is
// in flight at a time and ready is high only while the block is idle. Extend
// items that reach the collision check go from accept to result as follows:
// the accept edge registers the per-cell compares, two registered OR levels
// fold the hits, and the commit edge loads the result register. Ready returns
// the cycle after commit. Retract, clear and ignored items skip the OR levels
// and go from the accept edge straight to the finish state and commit. A result
// waits in the output register while the next item is accepted; an item only
// stalls at its commit cycle if that register is still full, and the collision
// flag is held across that stall. Sites above the walk length are stale and
// never compared.
// Configuration writes are taken at any time but belong to idle periods.
`default_nettype none
module self_avoiding_walk_site_stack import saw_pkg::*; #(
  parameter int MAX_LEN = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEN_W-1:0]     cfg_data,
  saw_in_if.sink                    in_ch,
  saw_out_if.source                 out_ch
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // configuration
  logic [DIM_W-1:0] dimensions;
  logic [LEN_W-1:0] target_length;

  // walk state
  logic [CNT_W-1:0] count, count_next;
  state_t           state, state_next;
  action_t          act, act_d;
  logic [STAT_W-1:0] pend_status, status_d;
  site_t            cand, cand_d;
  logic             cand_origin;

  // cell chain
  site_t            cell_site [MAX_LEN];
  logic [MAX_LEN-1:0] cell_hit;
  stack_ctl_t       ctl;
  logic             any_hit;
  logic             hit_hold, hold_valid, hit_live;

  // handshake and control
  logic in_fire, slot_free, commit, go_tree, collide, push_ok;
  site_t end_cur, end_next;
  logic [STAT_W-1:0] fin_status;
  logic [DIR_W-1:0] dir_limit;

  // output register
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [LEN_W-1:0]  out_len;
  site_t             out_site;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid || out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions    <= DIM_RESET;
      target_length <= TARGET_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_DIMENSIONS:    dimensions    <= cfg_data[DIM_W-1:0];
        CFG_TARGET_LENGTH: target_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // current end site is the top cell, or the origin for an empty walk
  assign end_cur = (count == '0) ? '0 : cell_site[0];

  // candidate site one step from the end
  always_comb begin
    cand_d = end_cur;
    unique case (in_ch.step_direction)
      DIR_PY:  cand_d.y = end_cur.y + COORD_W'(1);
      DIR_PX:  cand_d.x = end_cur.x + COORD_W'(1);
      DIR_NY:  cand_d.y = end_cur.y - COORD_W'(1);
      DIR_NX:  cand_d.x = end_cur.x - COORD_W'(1);
      DIR_PZ:  cand_d.z = end_cur.z + COORD_W'(1);
      DIR_NZ:  cand_d.z = end_cur.z - COORD_W'(1);
      default: cand_d = end_cur;
    endcase
  end

  assign dir_limit = (dimensions == DIM_3D) ? DIR_LIMIT_3D : DIR_LIMIT_2D;

  // decode an incoming word
  always_comb begin
    act_d    = ACT_NONE;
    status_d = ST_IGNORED;
    go_tree  = 1'b0;
    unique case (in_ch.opcode)
      OP_EXTEND: begin
        if ((CMP_W'(count) < CMP_W'(target_length)) && (count < CNT_MAX)
            && (in_ch.step_direction < dir_limit)) begin
          act_d    = ACT_PUSH;
          status_d = ST_EXTENDED;
          go_tree  = 1'b1;
        end
      end
      OP_RETRACT: begin
        if (count != '0) begin
          act_d    = ACT_POP;
          status_d = ST_RETRACTED;
        end
      end
      OP_CLEAR: begin
        act_d    = ACT_CLEAR;
        status_d = ST_RETRACTED;
      end
      default: ;
    endcase
  end

  // item registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act         <= act_d;
      pend_status <= status_d;
      cand        <= cand_d;
      cand_origin <= (cand_d == '0);
    end
  end

  // cell chain
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    site_t above_i, below_i;
    if (i == 0) begin : g_top
      assign above_i = cand;
    end else begin : g_mid
      assign above_i = cell_site[i-1];
    end
    if (i == MAX_LEN - 1) begin : g_bot
      assign below_i = '0;
    end else begin : g_low
      assign below_i = cell_site[i+1];
    end
    saw_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above_i),
      .below (below_i),
      .count (count),
      .cand  (cand_d),
      .site  (cell_site[i]),
      .hit   (cell_hit[i])
    );
  end

  saw_hit_tree #(.N(MAX_LEN)) u_tree (
    .clk     (clk),
    .hits    (cell_hit),
    .any_hit (any_hit)
  );

  // the tree shows the hits of an item for one cycle only, so hold them over a stall
  assign hit_live = hold_valid ? hit_hold : any_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hit_hold   <= 1'b0;
    end else if (commit) begin
      hold_valid <= 1'b0;
    end else if (state == S_FINISH) begin
      hold_valid <= 1'b1;
      hit_hold   <= hit_live;
    end
  end

  // commit decision
  always_comb begin
    collide    = hit_live || cand_origin;
    push_ok    = (act == ACT_PUSH) && !collide;
    fin_status = (act == ACT_PUSH) ? (collide ? ST_REJECTED : ST_EXTENDED) : pend_status;
    ctl.push   = commit && push_ok;
    ctl.pop    = commit && (act == ACT_POP);
    count_next = count;
    end_next   = end_cur;
    unique case (act)
      ACT_PUSH: begin
        if (push_ok) begin
          count_next = count + CNT_ONE;
          end_next   = cand;
        end
      end
      ACT_POP: begin
        count_next = count - CNT_ONE;
        end_next   = (count == CNT_ONE) ? '0 : cell_site[1];
      end
      ACT_CLEAR: begin
        count_next = '0;
        end_next   = '0;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) state_next = go_tree ? S_TREE1 : S_FINISH;
      end
      S_TREE1: state_next = S_TREE2;
      S_TREE2: state_next = S_FINISH;
      S_FINISH: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    unique case (state)
      S_IDLE:   in_ch.ready = 1'b1;
      S_FINISH: commit      = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (commit) count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status <= fin_status;
      out_len    <= LEN_W'(count_next);
      out_site   <= end_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.walk_length = out_len;
  assign out_ch.end_x       = out_site.x;
  assign out_ch.end_y       = out_site.y;
  assign out_ch.end_z       = out_site.z;

endmodule
`default_nettype wire

/* design/saw_checker.sv */
// port-level checks for the walk site stack, bound to the top level
`default_nettype none
module saw_checker import saw_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [STAT_W-1:0]         status,
  input wire logic [LEN_W-1:0]          walk_length,
  input wire logic signed [COORD_W-1:0] end_x,
  input wire logic signed [COORD_W-1:0] end_y,
  input wire logic signed [COORD_W-1:0] end_z
);

  logic [LEN_W-1:0] last_len;
  logic out_fire;

  assign out_fire = out_valid && out_ready;

  // length of the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_len <= '0;
    end else if (out_fire) begin
      last_len <= walk_length;
    end
  end

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item in flight");

  // a stalled result holds its length
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(walk_length))
    else $error("stalled result changed");

  // extend grows the walk by one step
  a_extend_len: assert property (@(posedge clk) disable iff (rst)
    out_fire && status == ST_EXTENDED |-> walk_length == last_len + LEN_W'(1))
    else $error("extend did not add one step");

  // rejected and ignored items leave the length alone
  a_keep_len: assert property (@(posedge clk) disable iff (rst)
    out_fire && (status == ST_REJECTED || status == ST_IGNORED)
    |-> walk_length == last_len)
    else $error("length changed on rejected or ignored item");

  // an empty walk sits at the origin
  a_empty_origin: assert property (@(posedge clk) disable iff (rst)
    out_fire && walk_length == '0 |-> end_x == '0 && end_y == '0 && end_z == '0)
    else $error("empty walk not at origin");

endmodule

bind self_avoiding_walk_site_stack saw_checker u_saw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .walk_length (out_ch.walk_length),
  .end_x       (out_ch.end_x),
  .end_y       (out_ch.end_y),
  .end_z       (out_ch.end_z)
);
`default_nettype wire

/* sim/self_avoiding_walk_site_stack_checker.sv */
// checker for the walk site stack: predicts each result word and compares it
`timescale 1ns / 1ps
module self_avoiding_walk_site_stack_checker import saw_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  saw_in_if                    in_mon,
  saw_out_if                   out_mon,
  output int                   outstanding,
  output int                   fail_count
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  walk_length;
    site_t             end_pos;
  } walk_result_t;

  // predicted walk: visited sites, step count, end site and register copies
  site_t            walk_sites [DEPTH];
  int               walk_len;
  site_t            walk_end;
  logic [DIM_W-1:0] dim_sel;
  logic [LEN_W-1:0] target_len;

  walk_result_t expected_results [$];
  int           mismatches;

  assign fail_count = mismatches;

  // apply one word to the predicted walk and return the result it causes
  function automatic walk_result_t predict_step(input logic [OP_W-1:0] op,
                                                input logic [DIR_W-1:0] dir);
    walk_result_t     res;
    site_t            cand;
    logic [DIR_W-1:0] dir_limit;
    logic             taken;
    res.status = ST_IGNORED;
    dir_limit = (dim_sel == DIM_3D) ? DIR_LIMIT_3D : DIR_LIMIT_2D;
    case (op)
      OP_EXTEND: begin
        if (walk_len < int'(target_len) && walk_len < DEPTH && dir < dir_limit) begin
          cand = walk_end;
          case (dir)
            DIR_PY:  cand.y = cand.y + 1'b1;
            DIR_PX:  cand.x = cand.x + 1'b1;
            DIR_NY:  cand.y = cand.y - 1'b1;
            DIR_NX:  cand.x = cand.x - 1'b1;
            DIR_PZ:  cand.z = cand.z + 1'b1;
            default: cand.z = cand.z - 1'b1;
          endcase
          // the origin and every stored site count as taken
          taken = (cand == '0);
          for (int i = 0; i < walk_len; i++) begin
            if (walk_sites[i] == cand) taken = 1'b1;
          end
          if (taken) begin
            res.status = ST_REJECTED;
          end else begin
            walk_sites[walk_len] = cand;
            walk_len = walk_len + 1;
            walk_end = cand;
            res.status = ST_EXTENDED;
          end
        end
      end
      OP_RETRACT: begin
        if (walk_len > 0) begin
          walk_len = walk_len - 1;
          walk_end = (walk_len == 0) ? site_t'('0) : walk_sites[walk_len - 1];
          res.status = ST_RETRACTED;
        end
      end
      OP_CLEAR: begin
        walk_len = 0;
        walk_end = '0;
        res.status = ST_RETRACTED;
      end
      default: ;
    endcase
    res.walk_length = LEN_W'(walk_len);
    res.end_pos = walk_end;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches = mismatches + 1;
    end
  endfunction

  // result words are checked before the word accepted at the same edge is queued
  always @(posedge clk) begin
    walk_result_t want;
    walk_result_t pred;
    if (rst) begin
      walk_len = 0;
      walk_end = '0;
      dim_sel = DIM_RESET;
      target_len = TARGET_RESET;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got status %0d length %0d",
                   $time, out_mon.status, out_mon.walk_length);
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("walk_length", want.walk_length, out_mon.walk_length);
          check_field("end_x", int'($signed(want.end_pos.x)), int'(out_mon.end_x));
          check_field("end_y", int'($signed(want.end_pos.y)), int'(out_mon.end_y));
          check_field("end_z", int'($signed(want.end_pos.z)), int'(out_mon.end_z));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pred = predict_step(in_mon.opcode, in_mon.step_direction);
        expected_results = {expected_results, pred};
      end
      if (cfg_write_en) begin
        if (cfg_index == CFG_DIMENSIONS) dim_sel = cfg_data[DIM_W-1:0];
        else target_len = cfg_data;
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

/* sim/self_avoiding_walk_site_stack_tb.sv */
// testbench top for the walk site stack: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module self_avoiding_walk_site_stack_tb;
  import saw_pkg::*;

  localparam int MAX_LEN = 1024;
  localparam int LIMIT_CYCLES = 500000;

  // codes outside the defined set
  localparam logic [OP_W-1:0]  OP_SPARE = 2'd3;
  localparam logic [DIR_W-1:0] DIR_TOP  = 3'd7;

  typedef enum logic {GEN_GROW, GEN_LINE} gen_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;
  int                   outstanding;
  int                   fail_count;

  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   items_sent;
  int                   phase_count;
  int                   cycle_count;
  logic [DIM_W-1:0]     cur_dims;
  logic [DIR_W-1:0]     last_dir;

  saw_in_if  in_ch ();
  saw_out_if out_ch ();

  self_avoiding_walk_site_stack #(.MAX_LEN(MAX_LEN)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

  self_avoiding_walk_site_stack_checker #(.DEPTH(MAX_LEN)) walk_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("self_avoiding_walk_site_stack regression: fail");
    $finish;
  end

  function automatic logic [DIR_W-1:0] opposite(input logic [DIR_W-1:0] dir);
    case (dir)
      DIR_PY:  return DIR_NY;
      DIR_NY:  return DIR_PY;
      DIR_PX:  return DIR_NX;
      DIR_NX:  return DIR_PX;
      DIR_PZ:  return DIR_NZ;
      default: return DIR_PZ;
    endcase
  endfunction

  // present one word after a random gap and hold it until accepted
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DIR_W-1:0] dir);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.step_direction <= dir;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  // hold off the sender until every result word has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // both registers are written back to back while the block is idle
  task automatic set_config(input logic [DIM_W-1:0] dims, input logic [LEN_W-1:0] target);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_DIMENSIONS;
    cfg_data <= LEN_W'(dims);
    @(posedge clk);
    cfg_index <= CFG_TARGET_LENGTH;
    cfg_data <= target;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cur_dims = dims;
  endtask

  // one random phase: grow mode favors non-reversing steps, line mode runs along +x
  task automatic run_phase(input logic [DIM_W-1:0] dims, input logic [LEN_W-1:0] target,
                           input int sidle, input int rstall, input gen_mode_t mode,
                           input int count);
    int               r;
    logic [OP_W-1:0]  op;
    logic [DIR_W-1:0] dir;
    set_config(dims, target);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    phase_count = phase_count + 1;
    // a line run starts from the origin
    if (mode == GEN_LINE) send_word(OP_CLEAR, DIR_PY);
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      op = OP_EXTEND;
      dir = DIR_W'($urandom_range(7));
      if (mode == GEN_LINE) begin
        dir = (r < 99) ? DIR_PX : DIR_NX;
      end else if (r < 72) begin
        do dir = DIR_W'($urandom_range(cur_dims == DIM_3D ? 5 : 3));
        while (dir == opposite(last_dir));
        last_dir = dir;
      end else if (r < 80) begin
        op = OP_EXTEND;
      end else if (r < 90) begin
        op = OP_RETRACT;
      end else if (r < 93) begin
        op = OP_CLEAR;
      end else begin
        op = OP_SPARE;
      end
      send_word(op, dir);
      if (mode == GEN_GROW && (n == count / 2 || $urandom_range(199) == 0)) wait_drained();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index <= CFG_DIMENSIONS;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_EXTEND;
    in_ch.step_direction <= DIR_PY;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    phase_count = 0;
    cur_dims = DIM_RESET;
    last_dir = DIR_PY;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty walk, ignored codes, collisions with origin and own path
    send_word(OP_RETRACT, DIR_PY);
    send_word(OP_CLEAR, DIR_PY);
    send_word(OP_EXTEND, DIR_PZ);
    send_word(OP_EXTEND, DIR_LIMIT_3D);
    send_word(OP_EXTEND, DIR_TOP);
    send_word(OP_SPARE, DIR_TOP);
    send_word(OP_EXTEND, DIR_PY);
    send_word(OP_EXTEND, DIR_NY);
    send_word(OP_EXTEND, DIR_PX);
    send_word(OP_EXTEND, DIR_NX);
    send_word(OP_EXTEND, DIR_NY);
    send_word(OP_EXTEND, DIR_NX);
    repeat (4) send_word(OP_RETRACT, DIR_PY);

    // directed: 3-D steps, full walk, then mode change with z kept
    set_config(DIM_3D, 11'd2);
    send_word(OP_EXTEND, DIR_PZ);
    send_word(OP_EXTEND, DIR_NZ);
    send_word(OP_EXTEND, DIR_PY);
    send_word(OP_EXTEND, DIR_PX);
    set_config(DIM_RESET, 11'd2);
    send_word(OP_RETRACT, DIR_PY);
    send_word(OP_EXTEND, DIR_PZ);
    send_word(OP_EXTEND, DIR_PX);
    send_word(OP_CLEAR, DIR_PY);

    // random phases
    run_phase(DIM_3D, 11'd1024, 0, 0, GEN_GROW, 250);
    run_phase(DIM_RESET, 11'd1, 74, 0, GEN_GROW, 100);
    run_phase(DIM_3D, 11'd37, 0, 74, GEN_GROW, 220);
    run_phase(DIM_RESET, 11'd1024, 0, 0, GEN_LINE, 1060);
    run_phase(DIM_RESET, 11'd20, 6, 6, GEN_GROW, 120);

    // drain and let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d words: directed checks plus %0d random phases", items_sent,
             phase_count);
    $display("2-D and 3-D modes, target lengths 1 to 1024, a straight run to full length");
    if (fail_count == 0) begin
      $display("self_avoiding_walk_site_stack regression: pass");
    end else begin
      $display("self_avoiding_walk_site_stack regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/saw_pkg.sv
design/saw_in_if.sv
design/saw_out_if.sv
design/saw_cell.sv
design/saw_hit_tree.sv
design/self_avoiding_walk_site_stack.sv
design/saw_checker.sv
sim/self_avoiding_walk_site_stack_checker.sv
sim/self_avoiding_walk_site_stack_tb.sv
